@@ design/dtu_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtu_pkg
// Shared types and constants for the degree trig unit: command/result
// structs, op codes, fixed-point formats and polynomial divisors.
// ----------------------------------------------------------------------------
package dtu_pkg;

	localparam int RESULT_FRAC_BITS_DEF = 24;
	localparam int CORE_FRAC = 28;
	localparam int CORE_ONE = 1 << CORE_FRAC;

	// degree formats (Q16.16)
	localparam int DEG_W = 33;
	localparam int MAG_DEG_W = 32;
	localparam int FULL_TURN = 23592960;
	localparam int HALF_TURN = 11796480;
	localparam int QUARTER_TURN = 5898240;
	localparam int FT_W = 25;
	localparam int HT_W = 24;
	localparam int TURN_STEPS = 8;

	// radians: r * pi * 2^32 / 180 = r * PI_QUO + floor(7 * r / 12)
	localparam int PI_QUO_W = 27;
	localparam logic [PI_QUO_W-1:0] PI_QUO = 27'd74961320;
	localparam logic [31:0] RECIP3 = 32'hAAAAAAAB;
	localparam int RECIP3_SH = 33;
	localparam int X_SHIFT = 20;
	localparam int X_W = 30;

	// core value widths
	localparam int S_W = 32;
	localparam int P_W = 31;
	localparam int POLY_TERMS = 7;
	localparam int POLY_DIV [POLY_TERMS] = '{182, 132, 90, 56, 30, 12, 2};

	localparam int Q_W = 32;
	localparam logic signed [31:0] VAL_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

	typedef enum logic [1:0] {
		OP_COS = 2'd0,
		OP_SIN = 2'd1,
		OP_TAN = 2'd2,
		OP_COT = 2'd3
	} op_t;

	typedef struct packed {
		op_t               op;
		logic signed [31:0] angle_deg;
	} trig_in_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               saturated;
	} trig_out_t;

	// side info that rides along the cosine pipeline
	typedef struct packed {
		logic neg;
		op_t  tag;
	} side_t;

	// divider control: a fixed result overrides the quotient
	typedef struct packed {
		logic               fixed;
		logic               fsat;
		logic               qneg;
		logic signed [31:0] fval;
	} div_ctl_t;

endpackage
`default_nettype wire

@@ design/dtu_reduce.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtu_reduce
// Reduces a Q16.16 degree angle modulo 360 by restoring subtraction, one
// step per stage, then folds it into [0,180) with a cosine sign flag.
// ----------------------------------------------------------------------------
module dtu_reduce (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic signed [dtu_pkg::DEG_W-1:0] deg,
	input  dtu_pkg::op_t                   in_tag,
	output logic                           out_valid,
	output logic [dtu_pkg::HT_W-1:0]       r,
	output dtu_pkg::side_t                 out_side
);
	import dtu_pkg::*;

	localparam int NSTEP = TURN_STEPS;

	logic                 vld_s [NSTEP+1];
	logic                 sgn_s [NSTEP+1];
	logic [MAG_DEG_W-1:0] mag_s [NSTEP+1];
	op_t                  tag_s [NSTEP+1];
	logic [DEG_W-1:0]     deg_abs;
	logic [FT_W-1:0]      m;
	logic [FT_W-1:0]      a1;

	assign deg_abs = deg[DEG_W-1] ? DEG_W'(-deg) : DEG_W'(deg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		sgn_s[0] <= deg[DEG_W-1];
		mag_s[0] <= deg_abs[MAG_DEG_W-1:0];
		tag_s[0] <= in_tag;
	end

	for (genvar j = 0; j < NSTEP; j++) begin : g_step
		localparam logic [MAG_DEG_W-1:0] SUB = MAG_DEG_W'(FULL_TURN) << (NSTEP - 1 - j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			sgn_s[j+1] <= sgn_s[j];
			tag_s[j+1] <= tag_s[j];
			mag_s[j+1] <= (mag_s[j] >= SUB) ? mag_s[j] - SUB : mag_s[j];
		end
	end

	// remainder keeps the sign of the angle; only a positive one above 180 wraps
	assign m  = mag_s[NSTEP][FT_W-1:0];
	assign a1 = (!sgn_s[NSTEP] && (m > FT_W'(HALF_TURN))) ? FT_W'(FULL_TURN) - m : m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vld_s[NSTEP];
		end
	end

	always_ff @(posedge clk) begin
		out_side.tag <= tag_s[NSTEP];
		if (a1 >= FT_W'(HALF_TURN)) begin
			r            <= HT_W'(a1 - FT_W'(HALF_TURN));
			out_side.neg <= 1'b1;
		end else begin
			r            <= a1[HT_W-1:0];
			out_side.neg <= 1'b0;
		end
	end

endmodule
`default_nettype wire

@@ design/dtu_poly_step.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtu_poly_step
// One nested Taylor step p' = 1 - trunc(s * p / (K * 2^28)) in three
// stages: product, reciprocal multiply, quotient correction.
// ----------------------------------------------------------------------------
module dtu_poly_step #(
	parameter int K = dtu_pkg::POLY_DIV[0]
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic [dtu_pkg::S_W-1:0]         s,
	input  logic signed [dtu_pkg::P_W-1:0]  p,
	input  dtu_pkg::side_t                  in_side,
	output logic                            out_valid,
	output logic [dtu_pkg::S_W-1:0]         out_s,
	output logic signed [dtu_pkg::P_W-1:0]  out_p,
	output dtu_pkg::side_t                  out_side
);
	import dtu_pkg::*;

	localparam int LOG_K = $clog2(K + 1) - 1;
	localparam int SH = 31 + LOG_K;
	localparam logic [31:0] RECIP = 32'((64'd1 << SH) / K);
	localparam int PM_W = CORE_FRAC + 1;
	localparam int V_W = S_W + PM_W;
	localparam int T_W = 32;

	logic             vld_s1, vld_s2;
	logic [S_W-1:0]   s_s1, s_s2;
	side_t            side_s1, side_s2;
	logic [V_W-1:0]   v_s1;
	logic [T_W-1:0]   t_s2;
	logic [63:0]      m_s2;
	logic [T_W-1:0]   t;
	logic [T_W-1:0]   qp;
	logic [T_W-1:0]   q;
	logic [39:0]      rem;
	logic signed [33:0] pn;

	// p entering a step is never negative and at most one
	assign t = v_s1[CORE_FRAC +: T_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			vld_s1    <= in_valid;
			vld_s2    <= vld_s1;
			out_valid <= vld_s2;
		end
	end

	assign qp  = T_W'(m_s2 >> SH);
	assign rem = 40'(t_s2) - 40'(qp) * 40'(K);
	assign q   = (rem >= 40'(K)) ? qp + 1'b1 : qp;
	assign pn  = 34'(CORE_ONE) - 34'(q);

	always_ff @(posedge clk) begin
		s_s1     <= s;
		side_s1  <= in_side;
		v_s1     <= s * p[PM_W-1:0];
		s_s2     <= s_s1;
		side_s2  <= side_s1;
		t_s2     <= t;
		m_s2     <= t * RECIP;
		out_s    <= s_s2;
		out_side <= side_s2;
		out_p    <= P_W'(pn);
	end

endmodule
`default_nettype wire

@@ design/dtu_cos_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtu_cos_core
// Cosine of a degree angle in Q.28: range reduction, conversion to
// radians, squaring and a seven-step nested polynomial.
// ----------------------------------------------------------------------------
module dtu_cos_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic signed [dtu_pkg::DEG_W-1:0] deg,
	input  dtu_pkg::op_t                     in_tag,
	output logic                             out_valid,
	output logic signed [dtu_pkg::P_W-1:0]   p,
	output dtu_pkg::op_t                     out_tag
);
	import dtu_pkg::*;

	localparam int PQ_W = HT_W + PI_QUO_W;
	localparam int W_W = HT_W + 1;
	localparam int W3_W = W_W + 32;
	localparam int XX_W = 2 * X_W;

	logic              rv;
	logic [HT_W-1:0]   rr;
	side_t             rside;

	logic              vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	side_t             side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [PQ_W-1:0]   prodq_s1, prodq_s2;
	logic [W_W-1:0]    w_s1;
	logic [W3_W-1:0]   w3_s2;
	logic [X_W-1:0]    x_s3;
	logic [XX_W-1:0]   xx_s4;
	logic [S_W-1:0]    s_s5;
	logic signed [P_W-1:0] p_s6;
	op_t               tag_s6;
	logic [PQ_W-1:0]   fl;

	logic              pv    [POLY_TERMS+1];
	logic [S_W-1:0]    ps    [POLY_TERMS+1];
	logic signed [P_W-1:0] pp [POLY_TERMS+1];
	side_t             pside [POLY_TERMS+1];

	dtu_reduce u_reduce (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.deg      (deg),
		.in_tag   (in_tag),
		.out_valid(rv),
		.r        (rr),
		.out_side (rside)
	);

	assign fl = prodq_s2 + PQ_W'(w3_s2 >> RECIP3_SH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s1 <= rv;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= pv[POLY_TERMS];
		end
	end

	always_ff @(posedge clk) begin
		side_s1  <= rside;
		prodq_s1 <= rr * PI_QUO;
		// floor(7r/12) as floor(floor(7r/4)/3)
		w_s1     <= W_W'((27'(rr) * 27'd7) >> 2);
		side_s2  <= side_s1;
		prodq_s2 <= prodq_s1;
		w3_s2    <= w_s1 * RECIP3;
		side_s3  <= side_s2;
		x_s3     <= X_W'((fl + PQ_W'(1 << (X_SHIFT - 1))) >> X_SHIFT);
		side_s4  <= side_s3;
		xx_s4    <= x_s3 * x_s3;
		side_s5  <= side_s4;
		s_s5     <= S_W'((xx_s4 + XX_W'(1 << (CORE_FRAC - 1))) >> CORE_FRAC);
		tag_s6   <= pside[POLY_TERMS].tag;
		p_s6     <= pside[POLY_TERMS].neg ? -pp[POLY_TERMS] : pp[POLY_TERMS];
	end

	assign pv[0]    = vld_s5;
	assign ps[0]    = s_s5;
	assign pp[0]    = P_W'(CORE_ONE);
	assign pside[0] = side_s5;

	for (genvar i = 0; i < POLY_TERMS; i++) begin : g_poly
		dtu_poly_step #(
			.K(POLY_DIV[i])
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (pv[i]),
			.s        (ps[i]),
			.p        (pp[i]),
			.in_side  (pside[i]),
			.out_valid(pv[i+1]),
			.out_s    (ps[i+1]),
			.out_p    (pp[i+1]),
			.out_side (pside[i+1])
		);
	end

	assign out_valid = vld_s6;
	assign p         = p_s6;
	assign out_tag   = tag_s6;

endmodule
`default_nettype wire

@@ design/dtu_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtu_div
// Pipelined signed restoring divider, one quotient bit per stage, with
// zero-divisor and overflow saturation. Direct values pass alongside.
// ----------------------------------------------------------------------------
module dtu_div #(
	parameter int FRAC = dtu_pkg::RESULT_FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            direct,
	input  logic signed [31:0]              dval,
	input  logic signed [dtu_pkg::P_W-1:0]  num,
	input  logic signed [dtu_pkg::P_W-1:0]  den,
	output logic                            out_valid,
	output dtu_pkg::trig_out_t              out_res
);
	import dtu_pkg::*;

	localparam int NW = P_W + FRAC;
	localparam int HI_W = NW - Q_W;

	logic           vld_s [Q_W+1];
	div_ctl_t       ctl_s [Q_W+1];
	logic [P_W-1:0] rem_s [Q_W+1];
	logic [Q_W-1:0] wrd_s [Q_W+1];
	logic [P_W-1:0] dd_s  [Q_W+1];

	logic [P_W-1:0]  num_mag, den_mag;
	logic [NW-1:0]   nsh;
	logic [HI_W-1:0] n_hi;
	logic            zden, ovf;
	div_ctl_t        ctl0;
	logic [Q_W-1:0]  q;
	div_ctl_t        cf;

	assign num_mag = num[P_W-1] ? P_W'(-num) : P_W'(num);
	assign den_mag = den[P_W-1] ? P_W'(-den) : P_W'(den);
	assign nsh     = {num_mag, {FRAC{1'b0}}};
	assign n_hi    = nsh[NW-1:Q_W];
	assign zden    = (den == '0);
	// quotient of 2^32 or more leaves the range either way
	assign ovf     = (P_W'(n_hi) >= den_mag);

	always_comb begin
		ctl0.qneg  = num[P_W-1] ^ den[P_W-1];
		ctl0.fixed = direct | zden | ovf;
		ctl0.fsat  = !direct & (zden | ovf);
		if (direct) begin
			ctl0.fval = dval;
		end else if (zden) begin
			ctl0.fval = num[P_W-1] ? VAL_MIN : VAL_MAX;
		end else begin
			ctl0.fval = ctl0.qneg ? VAL_MIN : VAL_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s[0] <= ctl0;
		rem_s[0] <= P_W'(n_hi);
		wrd_s[0] <= nsh[Q_W-1:0];
		dd_s[0]  <= den_mag;
	end

	for (genvar j = 0; j < Q_W; j++) begin : g_bit
		logic [P_W:0] rw;
		logic         qb;

		assign rw = {rem_s[j], wrd_s[j][Q_W-1]};
		assign qb = (rw >= {1'b0, dd_s[j]});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			ctl_s[j+1] <= ctl_s[j];
			dd_s[j+1]  <= dd_s[j];
			rem_s[j+1] <= qb ? P_W'(rw - {1'b0, dd_s[j]}) : rw[P_W-1:0];
			wrd_s[j+1] <= {wrd_s[j][Q_W-2:0], qb};
		end
	end

	assign q  = wrd_s[Q_W];
	assign cf = ctl_s[Q_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= vld_s[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (cf.fixed) begin
			out_res.value     <= cf.fval;
			out_res.saturated <= cf.fsat;
		end else if (cf.qneg) begin
			if (q > 32'h80000000) begin
				out_res.value     <= VAL_MIN;
				out_res.saturated <= 1'b1;
			end else begin
				out_res.value     <= 32'(-q);
				out_res.saturated <= 1'b0;
			end
		end else if (q[Q_W-1]) begin
			out_res.value     <= VAL_MAX;
			out_res.saturated <= 1'b1;
		end else begin
			out_res.value     <= 32'(q);
			out_res.saturated <= 1'b0;
		end
	end

endmodule
`default_nettype wire

@@ design/degree_trig_unit_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// degree_trig_unit_top
// Cosine, sine, tangent or cotangent of a Q16.16 degree angle, Q8.24 out.
// ----------------------------------------------------------------------------
// Usage:
//   Drive cmd (op, angle_deg) and raise start; the command transfers at the
//   rising edge where start is high and busy is low. busy is always low, so
//   a new command may transfer in every cycle.
//   Each command gives one result on result (value, saturated), marked by
//   done for exactly one cycle, in command order. The result path is
//   formed by two cosine pipelines running side by side (37 stages: 10 for
//   range reduction, 5 for radians and squaring, 3 per polynomial term and
//   one for the sign) followed by a 34-stage divider with one quotient bit
//   per stage; cosine and sine results ride the divider stages unchanged.
//   Throughput is one result per cycle.
//   The receiver cannot stall: done is a strobe and results must be taken
//   when shown. Reset clears all valid bits; nothing is in flight after it.
//   Tangent and cotangent saturate to the 32-bit limits and set saturated.
// ----------------------------------------------------------------------------
module degree_trig_unit_top #(
	parameter int RESULT_FRAC_BITS = dtu_pkg::RESULT_FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  dtu_pkg::trig_in_t  cmd,
	output logic               done,
	output dtu_pkg::trig_out_t result
);
	import dtu_pkg::*;

	localparam int SH_DN = (RESULT_FRAC_BITS < CORE_FRAC) ? CORE_FRAC - RESULT_FRAC_BITS : 0;
	localparam int SH_UP = (RESULT_FRAC_BITS > CORE_FRAC) ? RESULT_FRAC_BITS - CORE_FRAC : 0;
	localparam int HALF_LSB = (SH_DN > 0) ? (1 << (SH_DN - 1)) : 0;

	logic                    acc;
	logic signed [DEG_W-1:0] adeg, bdeg;
	logic                    cv, sv;
	logic signed [P_W-1:0]   cval, sval;
	op_t                     ctag;
	logic signed [P_W-1:0]   src, num, den;
	logic [P_W-1:0]          src_mag;
	logic [32:0]             conv_mag;
	logic signed [31:0]      dval;
	logic                    direct;

	assign busy = 1'b0;
	assign acc  = start & ~busy;
	assign adeg = DEG_W'(cmd.angle_deg);
	assign bdeg = DEG_W'(QUARTER_TURN) - adeg;

	dtu_cos_core u_cos (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (acc),
		.deg      (adeg),
		.in_tag   (cmd.op),
		.out_valid(cv),
		.p        (cval),
		.out_tag  (ctag)
	);

	// sine as cos(90 - a)
	dtu_cos_core u_sin (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (acc),
		.deg      (bdeg),
		.in_tag   (cmd.op),
		.out_valid(sv),
		.p        (sval),
		.out_tag  ()
	);

	always_comb begin
		case (ctag)
			OP_COS: begin
				direct = 1'b1;
				src    = cval;
				num    = cval;
				den    = sval;
			end
			OP_SIN: begin
				direct = 1'b1;
				src    = sval;
				num    = sval;
				den    = cval;
			end
			OP_TAN: begin
				direct = 1'b0;
				src    = sval;
				num    = sval;
				den    = cval;
			end
			default: begin
				direct = 1'b0;
				src    = cval;
				num    = cval;
				den    = sval;
			end
		endcase
	end

	// round half away from zero when narrowing, exact shift when widening
	assign src_mag  = src[P_W-1] ? P_W'(-src) : P_W'(src);
	assign conv_mag = ((33'(src_mag) + 33'(HALF_LSB)) >> SH_DN) << SH_UP;
	assign dval     = src[P_W-1] ? 32'(-conv_mag) : 32'(conv_mag);

	dtu_div #(
		.FRAC(RESULT_FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cv & sv),
		.direct   (direct),
		.dval     (dval),
		.num      (num),
		.den      (den),
		.out_valid(done),
		.out_res  (result)
	);

endmodule
`default_nettype wire

@@ tb/sv/tb_degree_trig_unit_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_degree_trig_unit_top
// Self-checking bench for the degree trig unit: directed angles and ops, then
// random commands with idle gaps, each result compared with a predicted value.
// ----------------------------------------------------------------------------
import dtu_pkg::*;

class trig_scoreboard;
	trig_out_t pending[$];
	int        n_fail;
	int        n_checked;

	// cosine of a Q16.16 degree angle, result in Q.28
	static function longint unsigned_cos(longint deg);
		longint r;
		longint unsigned prod;
		longint unsigned x;
		longint s;
		longint p;
		bit     neg;
		int     divs[7];
		divs = '{182, 132, 90, 56, 30, 12, 2};
		neg = 0;
		r = deg % 64'sd23592960;
		if (r > 64'sd11796480) r = r - 64'sd23592960;
		if (r < 0) r = -r;
		if (r >= 64'sd11796480) begin
			r = r - 64'sd11796480;
			neg = 1;
		end
		prod = longint'(r) * 64'h3243F6A89;
		x = ((prod / 180) + (64'd1 << 19)) >> 20;
		s = longint'((x * x + (64'd1 << 27)) >> 28);
		p = 64'sd1 << 28;
		for (int i = 0; i < 7; i++)
			p = (64'sd1 << 28) - (s * p) / (longint'(divs[i]) <<< 28);
		return neg ? -p : p;
	endfunction

	static function longint clip32(longint v, ref bit hit);
		if (v > 64'sd2147483647) begin
			hit = 1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			hit = 1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	static function longint to_q824(longint c);
		bit unused;
		longint v;
		unused = 0;
		v = (c >= 0) ? (c + 8) / 16 : -((-c + 8) / 16);
		return clip32(v, unused);
	endfunction

	static function longint ratio(longint num, longint den, ref bit sat);
		if (den == 0) begin
			sat = 1;
			return (num >= 0) ? 64'sd2147483647 : -64'sd2147483648;
		end
		return clip32((num <<< 24) / den, sat);
	endfunction

	function void note_cmd(trig_in_t c);
		longint a;
		longint cv;
		longint sv;
		longint v;
		bit     sat;
		trig_out_t r;
		a = longint'(c.angle_deg);
		cv = unsigned_cos(a);
		sv = unsigned_cos(64'sd5898240 - a);
		sat = 0;
		case (c.op)
			OP_COS: v = to_q824(cv);
			OP_SIN: v = to_q824(sv);
			OP_TAN: v = ratio(sv, cv, sat);
			default: v = ratio(cv, sv, sat);
		endcase
		r.value = v[31:0];
		r.saturated = sat;
		pending.push_back(r);
	endfunction

	function void check_result(trig_out_t got);
		trig_out_t want;
		n_checked++;
		if (pending.size() == 0) begin
			$error("result with nothing pending: value %h", got.value);
			n_fail++;
			return;
		end
		want = pending.pop_front();
		if (got.value !== want.value) begin
			$error("value: expected %h actual %h", want.value, got.value);
			n_fail++;
		end
		if (got.saturated !== want.saturated) begin
			$error("saturated: expected %b actual %b", want.saturated, got.saturated);
			n_fail++;
		end
	endfunction
endclass

module tb_degree_trig_unit_top;
	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	logic      done;
	trig_in_t  cmd;
	trig_out_t result;
	trig_scoreboard sb;
	bit        calm;

	degree_trig_unit_top u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cmd(cmd), .done(done), .result(result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk)
		if (arst_n && done) sb.check_result(result);

	// one command transfer, with an optional random idle ahead of it
	task automatic send_cmd(op_t op, logic [31:0] ang);
		while (!calm && $urandom_range(99) < 36) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		cmd.op <= op;
		cmd.angle_deg <= ang;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_cmd('{op: op, angle_deg: ang});
	endtask

	function automatic logic [31:0] rand_angle();
		case ($urandom_range(5))
			0: return $urandom();
			1: return {$urandom_range(400) * 32'd65536} * ($urandom_range(1) ? 1 : -1);
			2: return (32'($urandom_range(8)) * 32'd5898240)
				+ 32'($urandom_range(4)) - 32'd2;
			default: return 32'($signed($urandom_range(47185920))) - 32'sd23592960;
		endcase
	endfunction

	initial begin
		int directed[$];
		int waited;
		sb = new();
		calm = 0;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed = '{0, 5898240, 11796480, 17694720, 23592960, -5898240, -11796480,
			-17694720, 32'h7FFFFFFF, 32'h80000000, 1, -1, 2949120, 11796479};
		foreach (directed[i])
			for (int o = 0; o < 4; o++)
				send_cmd(op_t'(o), directed[i]);
		for (int n = 0; n < 1450; n++) begin
			calm = (n >= 600 && n < 800);
			send_cmd(op_t'($urandom_range(3)), rand_angle());
		end
		start <= 1'b0;
		waited = 0;
		while (sb.pending.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (80) @(posedge clk);
		$display("checked %0d results over all four ops, boundary and random angles",
			sb.n_checked);
		if (sb.n_fail == 0 && sb.pending.size() == 0)
			$display("[degree_trig_unit_top] OK");
		else
			$display("[degree_trig_unit_top] ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("[degree_trig_unit_top] ERROR");
		$finish;
	end
endmodule
